// ===== design/stk_pkg.sv =====
// Shared types and constants for the SNTP time keeper.
// Used by stk_div_step and sntp_time_keeper; depends on nothing else.
`default_nettype none

package stk_pkg;

  // Operation codes carried on s_tuser.
  localparam logic OP_SYNC  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Result status codes carried on m_tuser.
  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NOT_SYNCED = 2'd1,
    STATUS_PRE_1970   = 2'd2
  } stk_status_t;

  // Seconds from 1900-01-01 to 1970-01-01.
  localparam logic [31:0] NTP_UNIX_OFFSET = 32'd2208988800;
  // NTP fraction units per millisecond.
  localparam logic [22:0] FRAC_PER_MS     = 23'd4294967;
  localparam logic [9:0]  MS_PER_S        = 10'd1000;

  // floor(x / 125) == (x * RECIP_125) >> RECIP_SHIFT for every x below 2^31.
  localparam logic [31:0] RECIP_125   = 32'd2199023256;
  localparam int          RECIP_SHIFT = 38;

  // Item information that travels alongside the divider pipeline.
  typedef struct packed {
    logic        is_sync;
    stk_status_t status;
    logic [31:0] sec_base;
  } stk_side_t;

endpackage

`default_nettype wire

// ===== design/sntp_time_keeper.sv =====
// Throughput: one item per cycle while s_tready is high; s_tready stays high while
// any pipeline stage has room, even when a finished result is waiting on m_tready.
// Reset (rst, synchronous, active high) empties the pipeline and clears the sync tick
// and the stored time, so the block reports "not synchronised" until a sync arrives.
// Depends on stk_pkg and stk_div_step.
`default_nettype none

module sntp_time_keeper (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // s_tdata, lowest bit first: server_seconds[31:0], server_fraction[63:32],
  // sent_tick[127:64], now_tick[191:128]
  input  wire logic [191:0] s_tdata,
  // s_tuser: op[0] (0 sync, 1 query)
  input  wire logic         s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // m_tdata, lowest bit first: unix_seconds[63:0], milliseconds[73:64], zero padding
  output logic [79:0]       m_tdata,
  // m_tuser: status[1:0]
  output logic [1:0]        m_tuser
);

  // The pipeline has seven internal stages and the output register as stage eight.
  // A stage loads whenever it is empty or the stage after it moves on, so bubbles
  // are squeezed out and the input keeps flowing while the output is stalled.
  logic [8:1] vld;
  logic [9:1] en;

  always_comb begin
    en[9] = m_tready;
    for (int k = 8; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_tready = en[1];
  assign m_tvalid = vld[8];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= s_tvalid;
      end
      for (int k = 2; k <= 8; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Input unpacking.
  logic [31:0] in_seconds;
  logic [31:0] in_fraction;
  logic [63:0] in_sent;
  logic [63:0] in_now;
  logic        in_transfer;

  assign in_seconds  = s_tdata[31:0];
  assign in_fraction = s_tdata[63:32];
  assign in_sent     = s_tdata[127:64];
  assign in_now      = s_tdata[191:128];
  assign in_transfer = s_tvalid && s_tready;

  // The sync tick is taken at the input, so a query straight after a sync sees it.
  // A tick of zero means the block is not synchronised.
  logic [63:0] sync_tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_tick <= '0;
    end else if (in_transfer && s_tuser == stk_pkg::OP_SYNC) begin
      sync_tick <= in_now;
    end
  end

  // Front end: for a sync the dividend is half the round trip, and for a query it is
  // the time elapsed since the last sync. Both are then split into seconds and
  // milliseconds by the same divider.
  stk_pkg::stk_side_t side_in;
  logic [63:0]        round_trip;
  logic [63:0]        div_in;

  always_comb begin
    round_trip       = in_now - in_sent;
    side_in.is_sync  = (s_tuser == stk_pkg::OP_SYNC);
    side_in.sec_base = in_seconds - stk_pkg::NTP_UNIX_OFFSET;
    if (side_in.is_sync) begin
      div_in         = {1'b0, round_trip[63:1]};
      side_in.status = (in_seconds < stk_pkg::NTP_UNIX_OFFSET) ?
                       stk_pkg::STATUS_PRE_1970 : stk_pkg::STATUS_OK;
    end else begin
      div_in         = in_now - sync_tick;
      side_in.status = (sync_tick == 64'd0) ?
                       stk_pkg::STATUS_NOT_SYNCED : stk_pkg::STATUS_OK;
    end
  end

  // Stage registers for the side information.
  stk_pkg::stk_side_t s1_side, s2_side, s3_side, s4_side, s5_side, s6_side, s7_side;
  logic [63:0] s1_div;
  logic [31:0] s1_frac, s2_frac;
  logic [39:0] s2_low, s3_low;
  logic [15:0] s4_low, s5_low;
  logic [9:0]  s2_fq0;
  logic [9:0]  s3_fracms, s4_fracms, s5_fracms, s6_fracms, s7_fracms;
  logic [14:0] s4_q1, s5_q1, s6_q1, s7_q1;
  logic [23:0] s6_q2, s7_q2;

  // The fraction in milliseconds is estimated as (fraction * 1000) >> 32, which is at
  // most one below the true quotient by 4294967; one compare settles it.
  logic [41:0] frac_scaled;
  logic [32:0] fq0_back;
  logic [31:0] frac_left;
  logic [9:0]  fracms_next;

  assign frac_scaled = 42'(s1_frac) * 42'(stk_pkg::MS_PER_S);
  assign fq0_back    = 33'(s2_fq0) * 33'(stk_pkg::FRAC_PER_MS);
  assign frac_left   = s2_frac - fq0_back[31:0];
  assign fracms_next = s2_fq0 + 10'(frac_left >= 32'(stk_pkg::FRAC_PER_MS));

  // Divider digits: the top 24 bits, then the remainder with the next 24 bits,
  // then the remainder with the last 16 bits.
  logic [14:0] q1;
  logic [24:0] q2;
  logic [16:0] q3;
  logic [9:0]  r1, r2, r3;

  stk_div_step #(.IN_W(24)) u_digit1 (
    .clk       (clk),
    .en_mul    (en[2]),
    .en_rem    (en[3]),
    .dividend  (s1_div[63:40]),
    .quotient  (q1),
    .remainder (r1)
  );

  stk_div_step #(.IN_W(34)) u_digit2 (
    .clk       (clk),
    .en_mul    (en[4]),
    .en_rem    (en[5]),
    .dividend  ({r1, s3_low[39:16]}),
    .quotient  (q2),
    .remainder (r2)
  );

  stk_div_step #(.IN_W(26)) u_digit3 (
    .clk       (clk),
    .en_mul    (en[6]),
    .en_rem    (en[7]),
    .dividend  ({r2, s5_low}),
    .quotient  (q3),
    .remainder (r3)
  );

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_side <= side_in;
      s1_div  <= div_in;
      s1_frac <= in_fraction;
    end
    if (en[2]) begin
      s2_side <= s1_side;
      s2_low  <= s1_div[39:0];
      s2_frac <= s1_frac;
      s2_fq0  <= frac_scaled[41:32];
    end
    if (en[3]) begin
      s3_side   <= s2_side;
      s3_low    <= s2_low;
      s3_fracms <= fracms_next;
    end
    if (en[4]) begin
      s4_side   <= s3_side;
      s4_low    <= s3_low[15:0];
      s4_fracms <= s3_fracms;
      s4_q1     <= q1;
    end
    if (en[5]) begin
      s5_side   <= s4_side;
      s5_low    <= s4_low;
      s5_fracms <= s4_fracms;
      s5_q1     <= s4_q1;
    end
    if (en[6]) begin
      s6_side   <= s5_side;
      s6_fracms <= s5_fracms;
      s6_q1     <= s5_q1;
      s6_q2     <= q2[23:0];
    end
    if (en[7]) begin
      s7_side   <= s6_side;
      s7_fracms <= s6_fracms;
      s7_q1     <= s6_q1;
      s7_q2     <= s6_q2;
    end
  end

  // Stored time. It is read and written only as items leave the last stage, so items
  // see it strictly in arrival order.
  logic [63:0] base_seconds;
  logic [9:0]  base_millis;

  logic [63:0] quot;
  logic [63:0] sec_start;
  logic [9:0]  ms_add;
  logic [10:0] ms_sum;
  logic        ms_carry;
  logic [9:0]  ms_next;
  logic [63:0] sec_next;
  logic        ok_next;

  always_comb begin
    quot      = {9'd0, s7_q1, s7_q2, q3[15:0]};
    sec_start = s7_side.is_sync ? {32'd0, s7_side.sec_base} : base_seconds;
    ms_add    = s7_side.is_sync ? s7_fracms : base_millis;
    ms_sum    = 11'(r3) + 11'(ms_add);
    ms_carry  = (ms_sum >= 11'(stk_pkg::MS_PER_S));
    ms_next   = ms_carry ? 10'(ms_sum - 11'(stk_pkg::MS_PER_S)) : ms_sum[9:0];
    sec_next  = sec_start + quot + 64'(ms_carry);
    ok_next   = (s7_side.status == stk_pkg::STATUS_OK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_seconds <= '0;
      base_millis  <= '0;
    end else if (en[8] && vld[7] && s7_side.is_sync) begin
      // A timestamp before 1970 clears the stored time but keeps the sync tick.
      base_seconds <= ok_next ? sec_next : 64'd0;
      base_millis  <= ok_next ? ms_next : 10'd0;
    end
  end

  // Output register.
  logic [63:0] out_seconds;
  logic [9:0]  out_millis;
  logic [1:0]  out_status;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      out_seconds <= ok_next ? sec_next : 64'd0;
      out_millis  <= ok_next ? ms_next : 10'd0;
      out_status  <= s7_side.status;
    end
  end

  assign m_tdata = {6'd0, out_millis, out_seconds};
  assign m_tuser = out_status;

endmodule

`default_nettype wire

// ===== design/stk_div_step.sv =====
// One digit step of a long division by 1000: a multiply stage and a remainder stage.
// Depends on stk_pkg for the reciprocal constants.
`default_nettype none

module stk_div_step #(
  parameter int IN_W = 24
) (
  input  wire logic              clk,
  input  wire logic              en_mul,
  input  wire logic              en_rem,
  input  wire logic [IN_W-1:0]   dividend,
  output logic      [IN_W-10:0]  quotient,
  output logic      [9:0]        remainder
);

  localparam int QW = IN_W - 9;
  localparam int PW = IN_W + 29;

  logic [IN_W-4:0] scaled;
  logic [PW-1:0]   prod;
  logic [QW-1:0]   q_mul;
  logic [9:0]      low_mul;
  logic [19:0]     q_times_1000;

  // Dividing by 1000 is a shift by three followed by a reciprocal multiply for 125.
  assign scaled = dividend[IN_W-1:3];
  assign prod   = PW'(scaled) * PW'(stk_pkg::RECIP_125);

  always_ff @(posedge clk) begin
    if (en_mul) begin
      q_mul   <= prod[stk_pkg::RECIP_SHIFT +: QW];
      low_mul <= dividend[9:0];
    end
  end

  // The remainder is below 1024, so only the low ten bits of the product matter.
  assign q_times_1000 = 20'(q_mul[9:0]) * 20'(stk_pkg::MS_PER_S);

  always_ff @(posedge clk) begin
    if (en_rem) begin
      quotient  <= q_mul;
      remainder <= low_mul - q_times_1000[9:0];
    end
  end

endmodule

`default_nettype wire

// ===== bench/sntp_time_keeper_test.sv =====
// Self-checking bench for sntp_time_keeper: sync and query transfers go in on the
// slave stream and the returned wall-clock times are checked against a local model.
// Depends on stk_pkg and the sntp_time_keeper RTL only.
`default_nettype none

module sntp_time_keeper_test;
  timeunit 1ns;
  timeprecision 1ps;

  // One sync or query request as it travels on the slave side.
  typedef struct {
    logic        op;
    logic [31:0] ntp_sec;
    logic [31:0] ntp_frac;
    logic [63:0] sent_tick;
    logic [63:0] now_tick;
  } time_request_t;

  // One answer as it should appear on the master side.
  typedef struct {
    stk_pkg::stk_status_t status;
    logic [63:0]          unix_sec;
    logic [9:0]           millis;
  } wall_time_t;

  // How the two sides hold back during a phase of the run.
  typedef enum int {
    FLOW_FREE,
    FLOW_SEND_GAPS,
    FLOW_RECV_STALLS,
    FLOW_BOTH
  } flow_mode_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [191:0] s_tdata = '0;
  logic         s_tuser = stk_pkg::OP_SYNC;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [79:0]  m_tdata;
  logic [1:0]   m_tuser;

  sntp_time_keeper u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Requests waiting for the driver, and answers waiting for the block.
  time_request_t pending_requests[$];
  wall_time_t    awaited_times[$];
  time_request_t in_flight;

  int queued_total   = 0;
  int accepted_total = 0;
  int error_count    = 0;
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;

  // The generator's notion of the free-running millisecond tick.
  logic [63:0] gen_tick;

  // Local copy of the time keeper's state.
  logic [63:0] kept_sync_tick = '0;
  logic [63:0] kept_base_sec  = '0;
  logic [9:0]  kept_base_ms   = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Works out the answer to one accepted request and updates the kept time.
  function automatic wall_time_t predict_wall_time(time_request_t req);
    wall_time_t  ans;
    logic [63:0] total_ms;
    logic [63:0] elapsed;
    logic [63:0] ms_sum;
    ans.status   = stk_pkg::STATUS_OK;
    ans.unix_sec = '0;
    ans.millis   = '0;
    if (req.op == stk_pkg::OP_SYNC) begin
      // The receive tick is kept even when the timestamp is rejected.
      kept_sync_tick = req.now_tick;
      if (req.ntp_sec < stk_pkg::NTP_UNIX_OFFSET) begin
        kept_base_sec = '0;
        kept_base_ms  = '0;
        ans.status    = stk_pkg::STATUS_PRE_1970;
      end else begin
        // Fraction in whole milliseconds plus half the round trip, which
        // wraps modulo 2^64 and is halved with truncation.
        total_ms = 64'(req.ntp_frac) / 64'(stk_pkg::FRAC_PER_MS)
                   + ((req.now_tick - req.sent_tick) >> 1);
        kept_base_sec = 64'(req.ntp_sec - stk_pkg::NTP_UNIX_OFFSET)
                        + total_ms / 64'd1000;
        kept_base_ms  = 10'(total_ms % 64'd1000);
        ans.unix_sec  = kept_base_sec;
        ans.millis    = kept_base_ms;
      end
    end else if (kept_sync_tick == '0) begin
      // A sync tick of zero means the clock was never set.
      ans.status = stk_pkg::STATUS_NOT_SYNCED;
    end else begin
      elapsed      = req.now_tick - kept_sync_tick;
      ms_sum       = 64'(kept_base_ms) + elapsed % 64'd1000;
      ans.unix_sec = kept_base_sec + elapsed / 64'd1000 + ms_sum / 64'd1000;
      ans.millis   = 10'(ms_sum % 64'd1000);
    end
    return ans;
  endfunction

  task automatic add_sync(logic [31:0] sec, logic [31:0] frac,
                          logic [63:0] sent, logic [63:0] now);
    time_request_t req;
    req.op        = stk_pkg::OP_SYNC;
    req.ntp_sec   = sec;
    req.ntp_frac  = frac;
    req.sent_tick = sent;
    req.now_tick  = now;
    pending_requests.push_back(req);
    queued_total++;
  endtask

  task automatic add_query(logic [63:0] now);
    time_request_t req;
    req.op        = stk_pkg::OP_QUERY;
    req.ntp_sec   = $urandom;
    req.ntp_frac  = $urandom;
    req.sent_tick = {$urandom, $urandom};
    req.now_tick  = now;
    pending_requests.push_back(req);
    queued_total++;
  endtask

  // Mostly plausible traffic: a sync now and then, followed by queries at
  // later ticks. A share of the requests is pure noise or a rejected sync.
  task automatic queue_random_requests(int count);
    int          pick;
    logic [63:0] sent;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        if ($urandom_range(1) == 0)
          add_sync($urandom, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
        else
          add_query({$urandom, $urandom});
      end else if (pick < 30) begin
        // Now and again the tick source is restarted somewhere else.
        if ($urandom_range(99) < 5)
          gen_tick = {$urandom, $urandom};
        sent     = gen_tick;
        gen_tick = gen_tick + 64'($urandom_range(4000));
        if (pick < 16)
          add_sync($urandom_range(stk_pkg::NTP_UNIX_OFFSET - 1, 0), $urandom, sent,
                   gen_tick);
        else
          add_sync($urandom_range(32'hFFFF_FFFF, stk_pkg::NTP_UNIX_OFFSET), $urandom,
                   sent, gen_tick);
      end else begin
        if ($urandom_range(9) == 0)
          gen_tick = gen_tick + {$urandom, $urandom};
        else
          gen_tick = gen_tick + 64'($urandom_range(3000));
        add_query(gen_tick);
      end
    end
  endtask

  // Driver: offers the next pending request whenever the slave side is free.
  // The answer is predicted at the edge where the transfer completes.
  always @(posedge clk) begin : drive
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        awaited_times.push_back(predict_wall_time(in_flight));
        accepted_total++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_flight = pending_requests.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {in_flight.now_tick, in_flight.sent_tick,
                       in_flight.ntp_frac, in_flight.ntp_sec};
          s_tuser  <= in_flight.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every completed master transfer is matched with the oldest
  // awaited answer, field by field.
  always @(posedge clk) begin : collect
    wall_time_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited_times.size() == 0) begin
          $error("result with none awaited: status %0d, unix_seconds %0d, milliseconds %0d",
                 m_tuser, m_tdata[63:0], m_tdata[73:64]);
          error_count++;
        end else begin
          want = awaited_times.pop_front();
          if (m_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tuser);
            error_count++;
          end
          if (m_tdata[63:0] !== want.unix_sec) begin
            $error("unix_seconds: expected %0d, got %0d", want.unix_sec, m_tdata[63:0]);
            error_count++;
          end
          if (m_tdata[73:64] !== want.millis) begin
            $error("milliseconds: expected %0d, got %0d", want.millis, m_tdata[73:64]);
            error_count++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Stimulus and phase control.
  initial begin : stimulus
    flow_mode_t plan[8];
    plan = '{FLOW_FREE, FLOW_SEND_GAPS, FLOW_RECV_STALLS, FLOW_BOTH,
             FLOW_FREE, FLOW_BOTH, FLOW_SEND_GAPS, FLOW_RECV_STALLS};
    gen_tick = 64'd1_000_000;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: asking before any sync, rejected timestamps far below
    // and just below the 1970 boundary, the epoch itself, the largest seconds and
    // fraction, a round trip that wraps, the longest round trip, elapsed
    // time that wraps, and a sync taken at tick zero.
    add_query(64'd1000);
    add_sync(32'd0, 32'd0, 64'd5, 64'd10);
    add_query(64'd1234);
    add_sync(stk_pkg::NTP_UNIX_OFFSET - 1, 32'hFFFF_FFFF, 64'd100, 64'd200);
    add_sync(stk_pkg::NTP_UNIX_OFFSET, 32'd0, 64'd300, 64'd300);
    add_query(64'd300);
    add_sync(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd1000, 64'd2999);
    add_query(64'd2999 + 64'd999);
    add_sync(32'd3_900_000_000, 32'd4294966, 64'd50, 64'd49);
    add_query(64'd49 + 64'd999);
    add_sync(32'd3_900_000_000, 32'h8000_0000, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    add_query(64'hFFFF_FFFF_FFFF_FFFF);
    add_query(64'd5);
    add_sync(32'd3_800_000_000, 32'd12345, 64'd0, 64'd0);
    add_query(64'd777);
    add_sync(32'd3_800_000_000, 32'h7FFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA,
             64'hAAAA_AAAA_AAAA_AAAA + 64'd1500);
    add_query(64'hAAAA_AAAA_AAAA_AAAA + 64'd1500 + 64'd999_999);
    add_query(64'h5555_5555_5555_5555);
    add_sync(32'd1, $urandom, 64'd0, 64'd0);
    add_query(64'd42);

    foreach (plan[p]) begin
      case (plan[p])
        FLOW_FREE: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
        FLOW_SEND_GAPS: begin
          send_gap_pct   = 58;
          recv_stall_pct = 0;
        end
        FLOW_RECV_STALLS: begin
          send_gap_pct   = 0;
          recv_stall_pct = 58;
        end
        default: begin
          send_gap_pct   = 22;
          recv_stall_pct = 22;
        end
      endcase
      queue_random_requests(154);
      // The sender runs dry here and stays quiet until every answer is back.
      while (accepted_total != queued_total || awaited_times.size() != 0)
        @(posedge clk);
    end

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    // Give any stray result time to leave the pipeline.
    repeat (20) @(posedge clk);

    if (error_count == 0) begin
      $display("PASS sntp_time_keeper");
    end else begin
      $display("FAIL sntp_time_keeper");
    end
    $finish;
  end

  // Watchdog: a correct run takes well under a tenth of this.
  initial begin : watchdog
    #2_000_000;
    $display("FAIL sntp_time_keeper");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
design/stk_pkg.sv
design/stk_div_step.sv
design/sntp_time_keeper.sv
bench/sntp_time_keeper_test.sv
